// File: src/rlp_loc_pkg.sv
`default_nettype none
package rlp_loc_pkg;

  localparam int unsigned FIELD_W = 17;
  localparam int unsigned CFG_W   = 17;

  // header byte boundaries
  localparam logic [7:0] HDR_STR       = 8'h80;
  localparam logic [7:0] HDR_LONG_STR  = 8'hb8;
  localparam logic [7:0] HDR_LIST      = 8'hc0;
  localparam logic [7:0] HDR_LONG_LIST = 8'hf8;
  localparam logic [7:0] LL_STR_BASE   = 8'hb7;
  localparam logic [7:0] LL_LIST_BASE  = 8'hf7;

  typedef enum logic [0:0] {
    REG_TARGET_INDEX         = 1'b0,
    REG_SEARCH_IN_FIRST_LIST = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_HEAD    = 3'd0,
    PH_LEN     = 3'd1,
    PH_LISTLEN = 3'd2,
    PH_STOP    = 3'd3,
    PH_NOTLIST = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_FOUND_STRING   = 3'd0,
    ST_FOUND_LIST     = 3'd1,
    ST_ABSENT         = 3'd2,
    ST_OVERRUN        = 3'd3,
    ST_COUNT_OK       = 3'd4,
    ST_COUNT_MISMATCH = 3'd5,
    ST_NOT_LIST       = 3'd6
  } status_t;

  typedef struct packed {
    logic [CFG_W-1:0] target_index;
    logic             search_in_first_list;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] item_offset;
    logic [FIELD_W-1:0] item_length;
    logic [FIELD_W-1:0] item_count;
  } res_t;

endpackage
`default_nettype wire

// File: src/rlp_loc_in_reg.sv
`default_nettype none
module rlp_loc_in_reg
  import rlp_loc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic     last_byte,
  input  wire logic     take,
  output logic          q_valid,
  output in_item_t      q
);

  // free slot, or the held byte leaves this cycle
  assign in_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q.data_byte <= data_byte;
      q.last_byte <= last_byte;
    end
  end

endmodule
`default_nettype wire

// File: src/rlp_loc_walker.sv
`default_nettype none
module rlp_loc_walker
  import rlp_loc_pkg::*;
#(
  parameter longint unsigned MAX_BUFFER_BYTES = 65536
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     q_valid,
  input  wire in_item_t q,
  input  wire logic     res_stall,
  output logic          take,
  output logic          res_load,
  output res_t          res
);

  localparam int unsigned P  = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int unsigned LW = (P > 6) ? P : 6;
  localparam int unsigned E  = LW + 1;
  localparam int unsigned IW = (P > 16) ? P : 16;
  localparam int unsigned XW = (LW > FIELD_W) ? LW : FIELD_W;
  localparam logic [P-1:0]   BOUND     = P'(MAX_BUFFER_BYTES);
  localparam logic [P+7:0]   BOUND_ACC = (P + 8)'(MAX_BUFFER_BYTES);

  logic [P-1:0]  byte_position, byte_position_next;
  phase_t        phase, phase_next;
  logic [3:0]    len_left, len_left_next;
  logic [P-1:0]  acc, acc_next;
  logic          acc_big, acc_big_next;
  logic [E-1:0]  skip_until, skip_until_next;
  logic [P-1:0]  items_seen, items_seen_next;
  logic          found_valid, found_valid_next;
  logic          found_kind, found_kind_next;
  logic [P-1:0]  found_offset, found_offset_next;
  logic [LW-1:0] found_length, found_length_next;
  logic          region_open, region_open_next;
  logic [E-1:0]  region_end, region_end_next;
  logic          pending_kind, pending_kind_next;
  logic          pending_target, pending_target_next;

  // a last byte needs the result register free
  assign take     = q_valid && !(q.last_byte && res_stall);
  assign res_load = take && q.last_byte;

  always_comb begin : walk_next
    logic          do_done;
    logic          do_open;
    logic          d_tgt;
    logic          d_kind;
    logic [P-1:0]  d_off;
    logic [LW-1:0] d_len;
    logic [E-1:0]  sum;
    logic [P+7:0]  acc_shift;
    logic [3:0]    left_dec;
    logic [7:0]    b;
    logic          tgt;

    byte_position_next  = byte_position;
    phase_next          = phase;
    len_left_next       = len_left;
    acc_next            = acc;
    acc_big_next        = acc_big;
    skip_until_next     = skip_until;
    items_seen_next     = items_seen;
    found_valid_next    = found_valid;
    found_kind_next     = found_kind;
    found_offset_next   = found_offset;
    found_length_next   = found_length;
    region_open_next    = region_open;
    region_end_next     = region_end;
    pending_kind_next   = pending_kind;
    pending_target_next = pending_target;

    do_done   = 1'b0;
    do_open   = 1'b0;
    d_tgt     = 1'b0;
    d_kind    = 1'b0;
    d_off     = '0;
    d_len     = '0;
    b         = q.data_byte;
    acc_shift = {acc, b};
    left_dec  = (len_left != 4'd0) ? len_left - 4'd1 : len_left;
    tgt       = !cfg.target_index[CFG_W-1] &&
                (IW'(items_seen) == IW'(cfg.target_index[CFG_W-2:0]));

    // bytes beyond the bound are dropped
    if (take && (byte_position < BOUND)) begin
      byte_position_next = byte_position + 1'b1;
      unique case (phase)
        PH_HEAD: begin
          if ((byte_position == '0) && cfg.search_in_first_list) begin
            if (b < HDR_LIST) begin
              phase_next = PH_NOTLIST;
            end else if (b < HDR_LONG_LIST) begin
              do_open = 1'b1;
              d_off   = byte_position + 1'b1;
              d_len   = LW'(b - HDR_LIST);
            end else begin
              len_left_next = 4'(b - LL_LIST_BASE);
              acc_next      = '0;
              acc_big_next  = 1'b0;
              phase_next    = PH_LISTLEN;
            end
          end else if (E'(byte_position) >= skip_until) begin
            if (items_seen < BOUND) begin
              items_seen_next = items_seen + 1'b1;
            end
            d_tgt = tgt;
            if (b < HDR_STR) begin
              do_done = 1'b1;
              d_off   = byte_position;
              d_len   = LW'(1);
            end else if (b < HDR_LONG_STR) begin
              do_done = 1'b1;
              d_off   = byte_position + 1'b1;
              d_len   = LW'(b - HDR_STR);
            end else if (b < HDR_LIST) begin
              pending_kind_next   = 1'b0;
              len_left_next       = 4'(b - LL_STR_BASE);
              acc_next            = '0;
              acc_big_next        = 1'b0;
              pending_target_next = tgt;
              phase_next          = PH_LEN;
            end else if (b >= HDR_LONG_LIST) begin
              pending_kind_next   = 1'b1;
              len_left_next       = 4'(b - LL_LIST_BASE);
              acc_next            = '0;
              acc_big_next        = 1'b0;
              pending_target_next = tgt;
              phase_next          = PH_LEN;
            end else begin
              do_done = 1'b1;
              d_kind  = 1'b1;
              d_off   = byte_position + 1'b1;
              d_len   = LW'(b - HDR_LIST);
            end
          end
        end
        PH_LEN, PH_LISTLEN: begin
          // big-endian length, saturating sticky flag once above the bound
          acc_next      = acc_shift[P-1:0];
          acc_big_next  = acc_big || (acc_shift > BOUND_ACC);
          len_left_next = left_dec;
          if (left_dec == 4'd0) begin
            d_off = byte_position + 1'b1;
            d_len = acc_big_next ? LW'(BOUND) : LW'(acc_next);
            if (phase == PH_LISTLEN) begin
              do_open = 1'b1;
            end else begin
              do_done = 1'b1;
              d_tgt   = pending_target;
              d_kind  = pending_kind;
            end
          end
        end
        default: ;
      endcase
    end

    sum = E'(d_off) + E'(d_len);
    if (do_open) begin
      region_open_next = 1'b1;
      region_end_next  = sum;
      skip_until_next  = E'(d_off);
      phase_next       = (d_len == '0) ? PH_STOP : PH_HEAD;
    end else if (do_done) begin
      if (d_tgt) begin
        found_valid_next  = 1'b1;
        found_kind_next   = d_kind;
        found_offset_next = d_off;
        found_length_next = d_len;
        phase_next        = PH_STOP;
      end else begin
        skip_until_next = sum;
        phase_next      = (region_open && (sum >= region_end)) ? PH_STOP : PH_HEAD;
      end
    end
  end

  always_comb begin : walk_result
    logic [E-1:0]  total;
    logic [E-1:0]  e_end;
    logic [E-1:0]  f_end;
    logic          not_list;
    logic          bad;
    logic [XW-1:0] off_x;
    logic [XW-1:0] len_x;
    logic [XW-1:0] cnt_x;

    total    = E'(byte_position_next);
    e_end    = region_open_next ? region_end_next : total;
    f_end    = E'(found_offset_next) + E'(found_length_next);
    not_list = (phase_next == PH_NOTLIST) || (phase_next == PH_LISTLEN) ||
               (region_open_next && (region_end_next > total));
    bad      = (phase_next == PH_LEN) || (skip_until_next != e_end);
    off_x    = '0;
    len_x    = '0;
    cnt_x    = XW'(items_seen_next);

    if (not_list) begin
      res.status = ST_NOT_LIST;
      cnt_x      = '0;
    end else if (found_valid_next) begin
      if (f_end <= e_end) begin
        res.status = found_kind_next ? ST_FOUND_LIST : ST_FOUND_STRING;
        off_x      = XW'(found_offset_next);
        len_x      = XW'(found_length_next);
      end else begin
        res.status = ST_OVERRUN;
      end
    end else if (cfg.target_index[CFG_W-1]) begin
      res.status = bad ? ST_COUNT_MISMATCH : ST_COUNT_OK;
    end else if ((phase_next == PH_LEN) || (skip_until_next > e_end)) begin
      res.status = ST_OVERRUN;
    end else begin
      res.status = ST_ABSENT;
    end

    res.item_offset = off_x[FIELD_W-1:0];
    res.item_length = len_x[FIELD_W-1:0];
    res.item_count  = cnt_x[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || res_load) begin
      byte_position  <= '0;
      phase          <= PH_HEAD;
      len_left       <= '0;
      acc            <= '0;
      acc_big        <= 1'b0;
      skip_until     <= '0;
      items_seen     <= '0;
      found_valid    <= 1'b0;
      found_kind     <= 1'b0;
      found_offset   <= '0;
      found_length   <= '0;
      region_open    <= 1'b0;
      region_end     <= '0;
      pending_kind   <= 1'b0;
      pending_target <= 1'b0;
    end else begin
      byte_position  <= byte_position_next;
      phase          <= phase_next;
      len_left       <= len_left_next;
      acc            <= acc_next;
      acc_big        <= acc_big_next;
      skip_until     <= skip_until_next;
      items_seen     <= items_seen_next;
      found_valid    <= found_valid_next;
      found_kind     <= found_kind_next;
      found_offset   <= found_offset_next;
      found_length   <= found_length_next;
      region_open    <= region_open_next;
      region_end     <= region_end_next;
      pending_kind   <= pending_kind_next;
      pending_target <= pending_target_next;
    end
  end

  a_found_stops: assert property (@(posedge clk) disable iff (rst)
    found_valid |-> (phase == PH_STOP))
    else $error("found item but walk not stopped");

  a_len_pending: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_LEN) || (phase == PH_LISTLEN)) |-> (len_left != 4'd0))
    else $error("length phase with no length bytes left");

  a_items_bound: assert property (@(posedge clk) disable iff (rst)
    items_seen <= BOUND)
    else $error("item count above buffer bound");

  a_walk_cleared: assert property (@(posedge clk) disable iff (rst)
    res_load |=> ((byte_position == '0) && !found_valid && !region_open))
    else $error("walk state not cleared after result");

endmodule
`default_nettype wire

// File: src/rlp_loc_out_reg.sv
`default_nettype none
module rlp_loc_out_reg
  import rlp_loc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     res_load,
  input  wire res_t     res,
  output logic          res_stall,
  output logic          out_valid,
  input  wire logic     out_ready,
  output res_t          out_res
);

  assign res_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

// File: src/rlp_item_locator_top.sv
// result path: the input register holds the last byte, the walker decodes it and the output register holds the result
// throughput: one byte per cycle, set by the combinational header decode and skip
//   compare in the walker; a last byte waits only while the result register is full
//   and not being read in that cycle
// reset: synchronous rst clears the walk state, the handshake flags and both
//   configuration registers to zero; no clearing pass
`default_nettype none
module rlp_item_locator_top
  import rlp_loc_pkg::*;
#(
  parameter longint unsigned MAX_BUFFER_BYTES = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_addr,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic [FIELD_W-1:0]      item_offset,
  output logic [FIELD_W-1:0]      item_length,
  output logic [FIELD_W-1:0]      item_count
);

  cfg_t     cfg;
  logic     q_valid;
  in_item_t q;
  logic     take;
  logic     res_load;
  logic     res_stall;
  res_t     res;
  res_t     out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TARGET_INDEX:         cfg.target_index <= cfg_wdata;
        REG_SEARCH_IN_FIRST_LIST: cfg.search_in_first_list <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  rlp_loc_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .take      (take),
    .q_valid   (q_valid),
    .q         (q)
  );

  rlp_loc_walker #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q         (q),
    .res_stall (res_stall),
    .take      (take),
    .res_load  (res_load),
    .res       (res)
  );

  rlp_loc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .res_stall (res_stall),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign status      = out_res.status;
  assign item_offset = out_res.item_offset;
  assign item_length = out_res.item_length;
  assign item_count  = out_res.item_count;

endmodule
`default_nettype wire

// File: bench/tb_rlp_item_locator_top.sv
`timescale 1ns / 100ps
module tb_rlp_item_locator_top;
  import rlp_loc_pkg::*;

  localparam longint unsigned BUF_LIMIT      = 65536;
  localparam int              RESULT_LATENCY = 1;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [0:0]         cfg_addr;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               last_byte;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         status;
  logic [FIELD_W-1:0] item_offset;
  logic [FIELD_W-1:0] item_length;
  logic [FIELD_W-1:0] item_count;

  rlp_item_locator_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .item_offset (item_offset),
    .item_length (item_length),
    .item_count  (item_count)
  );

  always #1 clk = ~clk;

  // register shadows
  logic [16:0] tgt_reg;
  logic        list_reg;

  // walk state of the locator
  logic [16:0] w_pos;
  phase_t      w_phase;
  logic [3:0]  w_len_left;
  logic [63:0] w_len_acc;
  logic [63:0] w_skip;
  logic [16:0] w_seen;
  bit          w_found;
  bit          w_found_list;
  logic [63:0] w_found_off;
  logic [63:0] w_found_len;
  bit          w_region_open;
  logic [63:0] w_region_end;
  bit          w_pend_list;
  bit          w_pend_tgt;

  res_t        buffer_verdicts[$];
  logic [7:0]  frame_q[$];

  int          fail_count = 0;
  int          src_gap_pct = 0;
  int          sink_stall_pct = 0;
  int          sink_hold_cycles = 0;
  bit          offering = 1'b0;

  function automatic void walk_clear();
    w_pos = '0; w_phase = PH_HEAD; w_len_left = '0; w_len_acc = '0; w_skip = '0;
    w_seen = '0; w_found = 1'b0; w_found_list = 1'b0; w_found_off = '0;
    w_found_len = '0; w_region_open = 1'b0; w_region_end = '0;
    w_pend_list = 1'b0; w_pend_tgt = 1'b0;
  endfunction

  function automatic void move_on(logic [63:0] nxt);
    w_skip  = nxt;
    w_phase = (w_region_open && nxt >= w_region_end) ? PH_STOP : PH_HEAD;
  endfunction

  function automatic void close_item(bit hit, bit is_list, logic [63:0] off,
                                     logic [63:0] len);
    if (hit) begin
      w_found = 1'b1; w_found_list = is_list;
      w_found_off = off; w_found_len = len;
      w_phase = PH_STOP;
    end else begin
      move_on(off + len);
    end
  endfunction

  function automatic void enter_region(logic [63:0] start, logic [63:0] len);
    w_region_open = 1'b1;
    w_region_end  = start + len;
    move_on(start);
  endfunction

  function automatic void walk_header_byte(logic [7:0] b, logic [63:0] q);
    bit          hit;
    logic [63:0] len;
    if (w_phase == PH_HEAD) begin
      if (q == 0 && list_reg) begin
        // first header opens the searched list
        if (b < HDR_LIST) begin
          w_phase = PH_NOTLIST;
        end else if (b < HDR_LONG_LIST) begin
          enter_region(q + 1, 64'(b - HDR_LIST));
        end else begin
          w_len_left = 4'(b - LL_LIST_BASE); w_len_acc = '0; w_phase = PH_LISTLEN;
        end
      end else if (q >= w_skip) begin
        hit = !tgt_reg[16] && (w_seen == {1'b0, tgt_reg[15:0]});
        if (w_seen < BUF_LIMIT) w_seen = w_seen + 1'b1;
        if (b < HDR_STR) begin
          close_item(hit, 1'b0, q, 64'd1);
        end else if (b < HDR_LONG_STR) begin
          close_item(hit, 1'b0, q + 1, 64'(b - HDR_STR));
        end else if (b < HDR_LIST || b >= HDR_LONG_LIST) begin
          w_pend_list = (b >= HDR_LONG_LIST);
          w_len_left  = w_pend_list ? 4'(b - LL_LIST_BASE) : 4'(b - LL_STR_BASE);
          w_len_acc   = '0; w_pend_tgt = hit; w_phase = PH_LEN;
        end else begin
          close_item(hit, 1'b1, q + 1, 64'(b - HDR_LIST));
        end
      end
    end else if (w_phase == PH_LEN || w_phase == PH_LISTLEN) begin
      w_len_acc = {w_len_acc[55:0], b};
      if (w_len_left > 0) w_len_left = w_len_left - 1'b1;
      if (w_len_left == 0) begin
        len = (w_len_acc > BUF_LIMIT) ? 64'(BUF_LIMIT) : w_len_acc;
        if (w_phase == PH_LISTLEN) enter_region(q + 1, len);
        else close_item(w_pend_tgt, w_pend_list, q + 1, len);
      end
    end
  endfunction

  function automatic res_t walk_verdict();
    res_t        r;
    logic [63:0] total;
    logic [63:0] lim;
    total = {47'b0, w_pos};
    r = '0;
    r.item_count = w_seen;
    if (w_phase == PH_NOTLIST || w_phase == PH_LISTLEN ||
        (w_region_open && w_region_end > total)) begin
      r.status = ST_NOT_LIST;
      r.item_count = '0;
    end else begin
      lim = w_region_open ? w_region_end : total;
      if (w_found) begin
        if (w_found_off + w_found_len <= lim) begin
          r.status = w_found_list ? ST_FOUND_LIST : ST_FOUND_STRING;
          r.item_offset = w_found_off[16:0];
          r.item_length = w_found_len[16:0];
        end else begin
          r.status = ST_OVERRUN;
        end
      end else if (tgt_reg[16]) begin
        r.status = (w_phase == PH_LEN || w_skip != lim) ? ST_COUNT_MISMATCH : ST_COUNT_OK;
      end else begin
        r.status = (w_phase == PH_LEN || w_skip > lim) ? ST_OVERRUN : ST_ABSENT;
      end
    end
    return r;
  endfunction

  function automatic void rlp_walk_byte(logic [7:0] b, bit is_last);
    // bytes past the buffer bound are dropped
    if (w_pos < BUF_LIMIT) begin
      walk_header_byte(b, {47'b0, w_pos});
      w_pos = w_pos + 1'b1;
    end
    if (is_last) begin
      buffer_verdicts.push_back(walk_verdict());
      walk_clear();
    end
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (buffer_verdicts.size() == 0) begin
        $display("%0t: result transaction with none expected, expected nothing, actual status %0d",
                 $time, status);
        fail_count++;
      end else begin
        want = buffer_verdicts.pop_front();
        check_field("status", want.status, status);
        check_field("item_offset", want.item_offset, item_offset);
        check_field("item_length", want.item_length, item_length);
        check_field("item_count", want.item_count, item_count);
      end
    end
  end

  initial begin : result_sink
    int n;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        out_ready <= 1'b0;
        n = sink_hold_cycles;
        sink_hold_cycles = 0;
        repeat (n) @(posedge clk);
      end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit is_last);
    in_valid <= 1'b1; data_byte <= b; last_byte <= is_last;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    rlp_walk_byte(b, is_last);
    if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // bytes go out most significant first
  task automatic send_hex(input int n, input logic [127:0] v);
    int i;
    frame_q.delete();
    for (i = 0; i < n; i++) frame_q.push_back(v[8*(n-1-i) +: 8]);
    send_frame();
  endtask

  task automatic wait_drained();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (buffer_verdicts.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic configure(input logic [16:0] tgt, input bit in_list);
    wait_drained();
    cfg_we <= 1'b1; cfg_addr <= REG_TARGET_INDEX; cfg_wdata <= tgt;
    @(posedge clk);
    cfg_addr <= REG_SEARCH_IN_FIRST_LIST; cfg_wdata <= {16'b0, in_list};
    @(posedge clk);
    cfg_we <= 1'b0;
    tgt_reg = tgt;
    list_reg = in_list;
  endtask

  // header in front of n payload bytes that start at index at
  function automatic void put_header(bit is_list, int n, int at);
    logic [7:0] hb[$];
    int         v;
    int         k;
    if (n <= 55 && $urandom_range(7) != 0) begin
      hb.push_back(8'((is_list ? HDR_LIST : HDR_STR) + n));
    end else begin
      v = n;
      do begin
        hb.push_front(v[7:0]);
        v = v >> 8;
      end while (v != 0);
      if ($urandom_range(7) == 0) hb.push_front(8'h00);  // non-minimal length
      hb.push_front(8'((is_list ? LL_LIST_BASE : LL_STR_BASE) + hb.size()));
    end
    for (k = 0; k < hb.size(); k++) frame_q.insert(at + k, hb[k]);
  endfunction

  function automatic void add_string_item();
    int n;
    int at;
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) begin
      frame_q.push_back(8'($urandom_range(127)));
    end else begin
      if (pick < 8) n = $urandom_range(0, 6);
      else if (pick == 8) n = $urandom_range(7, 55);
      else n = $urandom_range(56, 60);
      at = frame_q.size();
      repeat (n) frame_q.push_back(8'($urandom_range(255)));
      put_header(1'b0, n, at);
    end
  endfunction

  function automatic void add_flat_list();
    int at;
    at = frame_q.size();
    repeat ($urandom_range(0, 3)) add_string_item();
    put_header(1'b1, frame_q.size() - at, at);
  endfunction

  function automatic void add_any_item();
    int at;
    int pick;
    pick = $urandom_range(19);
    if (pick < 12) begin
      add_string_item();
    end else if (pick < 17) begin
      add_flat_list();
    end else begin
      at = frame_q.size();
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(1) != 0) add_string_item();
        else add_flat_list();
      end
      put_header(1'b1, frame_q.size() - at, at);
    end
  endfunction

  function automatic void build_random_frame();
    frame_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(list_reg ? 0 : 1, 5)) add_any_item();
      if (list_reg && $urandom_range(9) != 0) put_header(1'b1, frame_q.size(), 0);
      if (frame_q.size() == 0) frame_q.push_back(8'($urandom_range(255)));
      // broken frames: cut tail, damaged byte, trailing junk
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 3)) if (frame_q.size() > 1) void'(frame_q.pop_back());
        1: frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom_range(255));
        2: repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(255)));
        default: ;
      endcase
    end
  endfunction

  function automatic logic [16:0] pick_target();
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) return 17'h1ffff;
    if (pick == 2) return 17'($urandom_range(0, 65535));
    return 17'($urandom_range(0, 6));
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  task automatic test_directed_headers();
    src_gap_pct = 20;
    sink_stall_pct = 20;
    configure(17'd0, 1'b0);
    send_hex(1, 'h00);
    send_hex(1, 'h7f);
    send_hex(1, 'h80);
    send_hex(4, 'hb8_02_aa_bb);
    send_hex(9, 72'hbf_ff_ff_ff_ff_ff_ff_ff_ff);  // saturated long length
    send_hex(3, 'hf8_01_00);
    send_hex(2, 'h82_01);                        // target payload past the end
    send_hex(2, 'hb9_01);                        // cut inside length bytes
    configure(17'd1, 1'b0);
    send_hex(4, 'h81_ff_c1_01);
    send_hex(2, 'h83_01);
    configure(17'h1ffff, 1'b0);
    send_hex(4, 'h01_80_c1_02);
    send_hex(3, 'h01_f9_00);
    send_hex(2, 'h83_01);
    configure(17'd65535, 1'b0);
    send_hex(2, 'h01_02);
  endtask

  task automatic test_directed_first_list();
    configure(17'd1, 1'b1);
    send_hex(5, 40'hc3_01_81_02_ee);             // trailing byte after the walk
    configure(17'd0, 1'b1);
    send_hex(2, 'h01_c0);
    send_hex(2, 'hf9_01);
    send_hex(2, 'hc5_01);
    send_hex(1, 'hc0);
    send_hex(4, 'hc1_b8_01_00);                  // inner length bytes past list end
    send_hex(4, 'hfa_ff_ff_01);
    configure(17'h1ffff, 1'b1);
    send_hex(1, 'hc0);
    send_hex(4, 'hc1_b8_01_00);
    send_hex(4, 'hf8_02_01_02);
  endtask

  task automatic test_result_backpressure();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    configure(17'd0, 1'b0);
    sink_hold_cycles = 300;
    repeat (10) begin
      build_random_frame();
      send_frame();
    end
    wait_drained();
  endtask

  task automatic test_random_frames(input int byte_budget, input bit with_idling);
    int fed;
    fed = 0;
    while (fed < byte_budget) begin
      configure(pick_target(), 1'($urandom_range(1)));
      src_gap_pct = with_idling ? pick_idle_pct() : 0;
      sink_stall_pct = with_idling ? pick_idle_pct() : 0;
      repeat ($urandom_range(4, 12)) begin
        build_random_frame();
        fed += frame_q.size();
        send_frame();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_TARGET_INDEX;
    cfg_wdata = '0;
    in_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    tgt_reg = '0;
    list_reg = 1'b0;
    walk_clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_headers();
    test_directed_first_list();
    test_result_backpressure();
    test_random_frames(800, 1'b1);
    test_random_frames(200, 1'b0);
    wait_drained();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
